[hdl/ilb_pkg.sv]
// Shared types and constants for the interrupt load balancer.
package ilb_pkg;

  localparam int COUNT_W     = 64;

  localparam logic [COUNT_W-1:0] COUNT_ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [COUNT_W-1:0] COUNT_NEAR_TOP = 64'hFFFF_FFFF_FFFF_FFFE;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_BALANCE_EN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYM_IO     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACT_CORES  = 2'd2;

  localparam int CORE_ID_W = 4;
  localparam int IRQ_W     = 5;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_INC,
    ST_SCAN,
    ST_CLEAR,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic sweep;
    logic load;
    logic inc;
    logic scan_step;
    logic route_set;
    logic clr_step;
  } cmd_t;

  typedef struct packed {
    logic sweep_done;
    logic in_range;
    logic balance_en;
    logic mod_hit;
    logic scan_done;
    logic wipe;
    logic clr_last;
  } sts_t;

endpackage

[hdl/interrupt_load_balancer_unit.sv]
// Top level: least-loaded interrupt routing with per-core, per-IRQ service counts.
// Path to the done strobe: an out-of-range beat goes straight to it; an in-range beat
//   first updates its count, then scans the cores on a reroute and clears the counts if needed.
// Throughput: one beat at a time, next start taken the cycle after done; results never stall.
// Reset restores state and configuration, then zeroes all 2**(clog2(MAX_CORES) +
//   clog2(IRQ_LINES)) count store entries (512 at defaults), one a cycle, with busy high.
module interrupt_load_balancer_unit
  import ilb_pkg::*;
#(
  parameter int MAX_CORES      = 16,
  parameter int IRQ_LINES      = 24,
  parameter int BALANCE_PERIOD = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  // command channel
  input  logic                  start,
  output logic                  busy,
  input  logic [CORE_ID_W-1:0]  core_id,
  input  logic [IRQ_W-1:0]      irq,
  // result channel
  output logic                  done,
  output logic                  eoi_to_local_apic,
  output logic                  route_valid,
  output logic [IRQ_W-1:0]      route_irq,
  output logic [CORE_ID_W-1:0]  route_core,
  output logic                  counts_cleared,
  // configuration writes
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Commands from the sequencer and status back to it.
  cmd_t cmd;
  sts_t sts;

  // Sequencer: reset sweep, read-modify-write of the count, remainder
  // check, scan for the least count, optional clear, then the result beat.
  ilb_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // Datapath: count store holding each count with its remainder modulo the
  // balance period, so the period check is a compare on the read-back entry.
  ilb_datapath #(
    .MAX_CORES      (MAX_CORES),
    .IRQ_LINES      (IRQ_LINES),
    .BALANCE_PERIOD (BALANCE_PERIOD)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_write         (cfg_write),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .core_id           (core_id),
    .irq               (irq),
    .eoi_to_local_apic (eoi_to_local_apic),
    .route_valid       (route_valid),
    .route_irq         (route_irq),
    .route_core        (route_core),
    .counts_cleared    (counts_cleared)
  );

  // A clear is only ever reported together with a reroute.
  a_clear_needs_route : assert property (@(posedge clk) disable iff (rst)
    (done && counts_cleared) |-> route_valid)
    else $error("counts_cleared without route_valid");

  // An accepted beat keeps the block busy on the next cycle.
  a_accept_busy : assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepting a beat");

  // The result strobe lasts one cycle and never overlaps the idle state.
  a_done_single : assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held for more than one cycle");

  // Scan and clear commands only occur once an in-range beat has been loaded.
  a_scan_in_range : assert property (@(posedge clk) disable iff (rst)
    (cmd.scan_step || cmd.clr_step || cmd.route_set) |-> sts.in_range)
    else $error("scan or clear on an out-of-range beat");

endmodule

[hdl/ilb_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module ilb_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[hdl/ilb_ctrl.sv]
// Sequencing state machine of the interrupt load balancer.
module ilb_ctrl
  import ilb_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  sts_t sts,
  output cmd_t cmd,
  output logic busy,
  output logic done
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    done       = 1'b0;
    case (state)
      ST_INIT: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_done) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = sts.in_range ? ST_INC : ST_DONE;
      end
      ST_INC: begin
        cmd.inc    = 1'b1;
        state_next = (sts.balance_en && sts.mod_hit) ? ST_SCAN : ST_DONE;
      end
      ST_SCAN: begin
        if (sts.scan_done) begin
          cmd.route_set = 1'b1;
          state_next    = sts.wipe ? ST_CLEAR : ST_DONE;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_next = ST_DONE;
      end
      ST_DONE: begin
        done       = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[hdl/ilb_datapath.sv]
// Count store with running remainders, least-count scan and result registers.
module ilb_datapath
  import ilb_pkg::*;
#(
  parameter int MAX_CORES      = 16,
  parameter int IRQ_LINES      = 24,
  parameter int BALANCE_PERIOD = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [CORE_ID_W-1:0]  core_id,
  input  logic [IRQ_W-1:0]      irq,
  output logic                  eoi_to_local_apic,
  output logic                  route_valid,
  output logic [IRQ_W-1:0]      route_irq,
  output logic [CORE_ID_W-1:0]  route_core,
  output logic                  counts_cleared
);

  localparam int CW    = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1;
  localparam int LW    = (IRQ_LINES > 1) ? $clog2(IRQ_LINES) : 1;
  localparam int AW    = CW + LW;
  localparam int DEPTH = 1 << AW;
  localparam int NW    = $clog2(MAX_CORES + 1);
  localparam int RW    = (BALANCE_PERIOD > 1) ? $clog2(BALANCE_PERIOD) : 1;
  localparam int EW    = COUNT_W + RW;
  localparam logic [RW-1:0] LAST_REM = RW'(BALANCE_PERIOD - 1);

  // configuration
  logic                  bal_en;
  logic                  sym_io;
  logic [CFG_DATA_W-1:0] act_cores;

  // item
  logic [CW-1:0]    core_r;
  logic [LW-1:0]    line_r;
  logic [IRQ_W-1:0] irq_r;
  logic             in_range;
  logic [NW-1:0]    scan_n;

  // count and its remainder modulo the balance period, kept side by side
  logic [COUNT_W-1:0] rd_count;
  logic [RW-1:0]      rd_rem;
  logic               cnt_wrap;
  logic [COUNT_W-1:0] inc_val;
  logic [RW-1:0]      rem_inc;

  // scan and clear
  logic [NW-1:0]      idx;
  logic               cmp_vld;
  logic [CW-1:0]      cmp_idx;
  logic [COUNT_W-1:0] best;
  logic [CW-1:0]      pick;
  logic               wipe;
  logic [NW-1:0]      clr_idx;
  logic               scan_issue;

  // reset sweep
  logic [AW-1:0] sweep_cnt;

  // RAM
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [EW-1:0] ram_rdata;

  ilb_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_counts (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign rd_count   = ram_rdata[COUNT_W-1:0];
  assign rd_rem     = ram_rdata[EW-1:COUNT_W];
  assign cnt_wrap   = (rd_count == COUNT_ALL_ONES);
  assign inc_val    = rd_count + COUNT_W'(1);
  // Advance the remainder with the count; a wrap to zero restarts it at zero.
  assign rem_inc    = (cnt_wrap || rd_rem == LAST_REM) ? '0 : rd_rem + RW'(1);
  assign scan_issue = cmd.scan_step && (idx < scan_n);

  always_comb begin
    ram_we    = cmd.sweep || cmd.inc || cmd.clr_step;
    ram_wdata = cmd.inc ? {rem_inc, inc_val} : '0;
    if (cmd.sweep) begin
      ram_waddr = sweep_cnt;
    end else if (cmd.clr_step) begin
      ram_waddr = {clr_idx[CW-1:0], line_r};
    end else begin
      ram_waddr = {core_r, line_r};
    end
    ram_raddr = scan_issue ? {idx[CW-1:0], line_r} : {core_r, line_r};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bal_en    <= 1'b0;
      sym_io    <= 1'b0;
      act_cores <= CFG_DATA_W'(1);
      sweep_cnt <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_BALANCE_EN: bal_en    <= cfg_data[0];
          CFG_SYM_IO:     sym_io    <= cfg_data[0];
          CFG_ACT_CORES:  act_cores <= cfg_data;
          default:        ;
        endcase
      end
      if (cmd.sweep) sweep_cnt <= sweep_cnt + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      core_r   <= CW'(core_id);
      line_r   <= LW'(irq);
      irq_r    <= irq;
      in_range <= (int'(core_id) < MAX_CORES) && (int'(irq) < IRQ_LINES);
      if (act_cores == '0) begin
        scan_n <= NW'(1);
      end else if (int'(act_cores) > MAX_CORES) begin
        scan_n <= NW'(MAX_CORES);
      end else begin
        scan_n <= NW'(act_cores);
      end
      idx            <= '0;
      cmp_vld        <= 1'b0;
      best           <= COUNT_ALL_ONES;
      pick           <= '0;
      wipe           <= 1'b0;
      clr_idx        <= '0;
      route_valid    <= 1'b0;
      route_irq      <= '0;
      route_core     <= '0;
      counts_cleared <= 1'b0;
    end
    if (cmd.scan_step) begin
      cmp_vld <= scan_issue;
      if (scan_issue) begin
        cmp_idx <= idx[CW-1:0];
        idx     <= idx + NW'(1);
      end
      if (cmp_vld) begin
        if (rd_count < best) begin
          best <= rd_count;
          pick <= cmp_idx;
        end else if (rd_count >= COUNT_NEAR_TOP) begin
          wipe <= 1'b1;
        end
      end
    end
    if (cmd.route_set) begin
      route_valid    <= 1'b1;
      route_irq      <= irq_r;
      route_core     <= CORE_ID_W'(pick);
      counts_cleared <= wipe;
    end
    if (cmd.clr_step) clr_idx <= clr_idx + NW'(1);
  end

  assign eoi_to_local_apic = sym_io;

  always_comb begin
    sts            = '0;
    sts.sweep_done = (sweep_cnt == '1);
    sts.in_range   = in_range;
    sts.balance_en = bal_en;
    sts.mod_hit    = !cnt_wrap && (rd_rem == LAST_REM);
    sts.scan_done  = (idx == scan_n) && !cmp_vld;
    sts.wipe       = wipe;
    sts.clr_last   = (clr_idx == scan_n - NW'(1));
  end

endmodule
